### rtl/sphere_through_four_points_macros.svh
// Assertion helpers for the sphere solver.
// Both sample on clock and are off while reset is high.
`ifndef SPHERE_THROUGH_FOUR_POINTS_MACROS_SVH
`define SPHERE_THROUGH_FOUR_POINTS_MACROS_SVH

// Same-cycle implication.
`define STP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stp assertion failed");

// Next-cycle implication.
`define STP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stp assertion failed");

`endif

### rtl/stp_pkg.sv
package stp_pkg;

   localparam int CW    = 32;           // coordinate width
   localparam int MW    = CW + 2;       // matrix coefficient, 2 * difference
   localparam int SQW   = 2 * CW;       // square of one coordinate
   localparam int RHW   = SQW + 2;      // right-hand side, difference of norms
   localparam int PRW   = 2 * MW;       // 2x2 minor product
   localparam int OPW   = 70;           // wide operand: cofactor or rhs
   localparam int HLW   = OPW / 2;      // split point of a wide operand
   localparam int PPW   = 2 * (HLW + 1);// partial product
   localparam int WPW   = 2 * OPW;      // full wide product
   localparam int WN    = WPW + 2;      // determinant and numerators
   localparam int UW    = WN + 1;       // divider dividend / divisor
   localparam int QB    = CW + 1;       // quotient bits before saturation
   localparam int SW    = 2 * QB;       // squared distance term
   localparam int RB    = 36;           // root bits
   localparam int RW    = 2 * RB + 2;   // root remainder
   localparam int RAD_W = CW - 1;       // radius width
   localparam int NPROD = 12;           // 3 det terms + 9 numerator terms
   localparam int QDEPTH = 4;
   localparam int QAW   = $clog2(QDEPTH);

   localparam logic [QB-1:0] LIM_POS = {2'b00, {(CW-1){1'b1}}};
   localparam logic [QB-1:0] LIM_NEG = {2'b01, {(CW-1){1'b0}}};

   // work handed from front to back
   typedef struct packed {
      logic                  sing;
      logic [WN-1:0]         det;
      logic [2:0][WN-1:0]    num;
      logic [2:0][CW-1:0]    a;
   } stp_job_type;

   // side data along the divider
   typedef struct packed {
      logic               sing;
      logic [2:0][CW-1:0] a;
      logic [2:0]         neg;
      logic [2:0]         ovf;
   } stp_dside_type;

   // side data along the square root
   typedef struct packed {
      logic               sing;
      logic [2:0][CW-1:0] ctr;
   } stp_rside_type;

   // queue status seen by the top level
   typedef struct packed {
      logic full;
      logic empty;
      logic push;
      logic pop;
   } stp_qstat_type;

endpackage

### rtl/stp_front.sv
module stp_front import stp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [3:0][2:0][CW-1:0]  in_pts,
   output logic                     out_valid,
   input  logic                     out_ready,
   output stp_job_type              out_job
);

   localparam int NF = 7;

   logic [NF-1:0]                   v_ff, v_in;
   logic                            en;
   logic [2:0][2:0][MW-1:0]         m_ff, m_in;
   logic [3:0][2:0][SQW-1:0]        sq_ff, sq_in;
   logic [2:0][RHW-1:0]             rhs2_ff, rhs2_in, rhs3_ff;
   logic [2:0][2:0][PRW-1:0]        pa_ff, pa_in, pb_ff, pb_in;
   logic [2:0][MW-1:0]              m02_ff, m03_ff;
   logic [2:0][2:0][OPW-1:0]        cof_ff, cof_in;
   logic [NPROD-1:0][3:0][PPW-1:0]  pp_ff, pp_in;
   logic [NPROD-1:0][WPW-1:0]       prod_ff, prod_in;
   logic [WN-1:0]                   det_ff, det_in;
   logic [2:0][WN-1:0]              num_ff, num_in;
   logic [NF-2:0][2:0][CW-1:0]      a_ff;
   stp_job_type                     job_ff, job_in;

   assign en        = !v_ff[NF-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[NF-1];
   assign out_job   = job_ff;
   assign v_in      = {v_ff[NF-2:0], in_valid};

   always_comb begin
      logic [CW:0]             dif;
      logic signed [SQW-1:0]   s;
      logic [3:0][RHW-1:0]     nrm;
      logic signed [OPW-1:0]   ea, eb, xs;
      logic [OPW-1:0]          x, y;
      logic [HLW:0]            xl, xh, yl, yh;
      logic signed [WPW-1:0]   t0, t1, t2, t3;
      logic signed [WN-1:0]    u0, u1, u2;
      int                      r1, r2, c1, c2, n;

      // coefficients and squares
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            dif = {in_pts[i+1][j][CW-1], in_pts[i+1][j]} - {in_pts[i][j][CW-1], in_pts[i][j]};
            m_in[i][j] = {dif, 1'b0};
         end
      end
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < 3; j++) begin
            s = $signed(in_pts[k][j]) * $signed(in_pts[k][j]);
            sq_in[k][j] = s;
         end
      end

      // norms and minor products
      for (int k = 0; k < 4; k++) begin
         nrm[k] = RHW'(sq_ff[k][0]) + RHW'(sq_ff[k][1]) + RHW'(sq_ff[k][2]);
      end
      for (int i = 0; i < 3; i++) begin
         rhs2_in[i] = nrm[i+1] - nrm[i];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r1 = (i == 0) ? 1 : 0;
            r2 = (i == 2) ? 1 : 2;
            c1 = (j == 0) ? 1 : 0;
            c2 = (j == 2) ? 1 : 2;
            pa_in[i][j] = $signed(m_ff[r1][c1]) * $signed(m_ff[r2][c2]);
            pb_in[i][j] = $signed(m_ff[r1][c2]) * $signed(m_ff[r2][c1]);
         end
      end

      // signed cofactors
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ea = $signed(pa_ff[i][j]);
            eb = $signed(pb_ff[i][j]);
            cof_in[i][j] = (((i + j) & 1) == 0) ? ea - eb : eb - ea;
         end
      end

      // partial products: det = sum m0j*C0j, num c = sum rhs i * C ic
      for (int p = 0; p < NPROD; p++) begin
         pp_in[p] = '0;
      end
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 4; i++) begin
            if (i == 3) begin
               n  = c;
               xs = $signed(m03_ff[c]);
               y  = cof_ff[0][c];
            end else begin
               n  = 3 + 3 * c + i;
               xs = $signed(rhs3_ff[i]);
               y  = cof_ff[i][c];
            end
            x  = xs;
            xl = {1'b0, x[HLW-1:0]};
            xh = {x[OPW-1], x[OPW-1:HLW]};
            yl = {1'b0, y[HLW-1:0]};
            yh = {y[OPW-1], y[OPW-1:HLW]};
            pp_in[n][0] = $signed(xh) * $signed(yh);
            pp_in[n][1] = $signed(xh) * $signed(yl);
            pp_in[n][2] = $signed(xl) * $signed(yh);
            pp_in[n][3] = $signed(xl) * $signed(yl);
         end
      end

      // recombine
      for (int p = 0; p < NPROD; p++) begin
         t0 = $signed(pp_ff[p][0]);
         t1 = $signed(pp_ff[p][1]);
         t2 = $signed(pp_ff[p][2]);
         t3 = $signed(pp_ff[p][3]);
         prod_in[p] = (t0 << (2 * HLW)) + ((t1 + t2) << HLW) + t3;
      end

      // sums
      u0 = $signed(prod_ff[0]);
      u1 = $signed(prod_ff[1]);
      u2 = $signed(prod_ff[2]);
      det_in = u0 + u1 + u2;
      for (int c = 0; c < 3; c++) begin
         u0 = $signed(prod_ff[3 + 3 * c]);
         u1 = $signed(prod_ff[4 + 3 * c]);
         u2 = $signed(prod_ff[5 + 3 * c]);
         num_in[c] = u0 + u1 + u2;
      end

      // classify
      job_in.sing = (det_ff == '0);
      job_in.det  = det_ff;
      job_in.num  = num_ff;
      job_in.a    = a_ff[NF-2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff    <= m_in;
         sq_ff   <= sq_in;
         rhs2_ff <= rhs2_in;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         m02_ff  <= m_ff[0];
         cof_ff  <= cof_in;
         rhs3_ff <= rhs2_ff;
         m03_ff  <= m02_ff;
         pp_ff   <= pp_in;
         prod_ff <= prod_in;
         det_ff  <= det_in;
         num_ff  <= num_in;
         job_ff  <= job_in;
         a_ff[0] <= in_pts[0];
         for (int k = 1; k < NF - 1; k++) begin
            a_ff[k] <= a_ff[k-1];
         end
      end
   end

endmodule

### rtl/stp_queue.sv
module stp_queue import stp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  stp_job_type   push_job,
   output logic          pop_valid,
   input  logic          pop_ready,
   output stp_job_type   pop_job,
   output stp_qstat_type stat
);

   localparam logic [QAW:0] QFULL = (QAW + 1)'(QDEPTH);

   stp_job_type      mem_ff [QDEPTH];
   logic [QAW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QAW:0]     cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != QFULL);
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = mem_ff[rp_ff];

   assign stat.full  = !push_ready;
   assign stat.empty = !pop_valid;
   assign stat.push  = push;
   assign stat.pop   = pop;

   always_comb begin
      wp_in  = push ? wp_ff + QAW'(1) : wp_ff;
      rp_in  = pop  ? rp_ff + QAW'(1) : rp_ff;
      cnt_in = cnt_ff + (QAW + 1)'(push) - (QAW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_job;
      end
   end

endmodule

### rtl/stp_back.sv
module stp_back import stp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  stp_job_type          in_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [2:0][CW-1:0]   out_center,
   output logic [RAD_W-1:0]     out_radius,
   output logic                 out_singular
);

   localparam int NDIV = QB;
   localparam int NSQ  = RB;
   localparam int NB   = NDIV + NSQ + 8;

   logic [NB-1:0]                v_ff, v_in;
   logic                         en;
   // abs stage
   logic [2:0][WN-1:0]           an_ff, an_in;
   logic [WN-1:0]                ad_ff, ad_in;
   stp_dside_type                s0_ff, s0_in, s1_ff;
   // dividend / divisor stage
   logic [2:0][UW-1:0]           nn_ff, nn_in;
   logic [UW-1:0]                dn1_ff, dn1_in;
   // divider chain
   logic [NDIV:0][2:0][UW-1:0]   rem_ff, rem_in;
   logic [NDIV:0][2:0][QB-1:0]   quo_ff, quo_in;
   logic [NDIV:0][UW-1:0]        den_ff;
   stp_dside_type [NDIV:0]       ds_ff, ds_in;
   // centre and distance
   logic [2:0][CW-1:0]           ctr_ff, ctr_in, bfa_ff;
   logic                         bfs_ff;
   logic [2:0][CW:0]             dd_ff, dd_in;
   logic [2:0][SW-1:0]           sqd_ff, sqd_in;
   stp_rside_type                r1s_ff, r2s_ff;
   // root chain
   logic [NSQ:0][RW-1:0]         srem_ff, srem_in;
   logic [NSQ:0][RB-1:0]         root_ff, root_in;
   stp_rside_type [NSQ:0]        rs_ff;
   // output register
   logic [2:0][CW-1:0]           cen_ff, cen_in;
   logic [RAD_W-1:0]             rad_ff, rad_in;
   logic                         sng_ff;

   assign en           = !v_ff[NB-1] || out_ready;
   assign in_ready     = en;
   assign out_valid    = v_ff[NB-1];
   assign out_center   = cen_ff;
   assign out_radius   = rad_ff;
   assign out_singular = sng_ff;
   assign v_in         = {v_ff[NB-2:0], in_valid};

   always_comb begin
      logic [QB-1:0]  q, lim, qs, qn;
      logic [RW-1:0]  t;
      logic [RB:0]    rr;
      logic [RB-1:0]  r;
      int             k;

      // magnitudes and quotient signs
      for (int c = 0; c < 3; c++) begin
         an_in[c] = in_job.num[c][WN-1] ? ~in_job.num[c] + WN'(1) : in_job.num[c];
         s0_in.neg[c] = in_job.num[c][WN-1] ^ in_job.det[WN-1];
      end
      ad_in    = in_job.det[WN-1] ? ~in_job.det + WN'(1) : in_job.det;
      s0_in.sing = in_job.sing;
      s0_in.a    = in_job.a;
      s0_in.ovf  = '0;

      // round to nearest: (2|n| + |d|) / (2|d|)
      for (int c = 0; c < 3; c++) begin
         nn_in[c] = (UW'(an_ff[c]) << 1) + UW'(ad_ff);
      end
      dn1_in = UW'(ad_ff) << 1;

      // chain head: overflow check, quotient cannot exceed QB bits otherwise
      ds_in[0] = s1_ff;
      for (int c = 0; c < 3; c++) begin
         ds_in[0].ovf[c] = (nn_ff[c] >> QB) >= dn1_ff;
         rem_in[0][c] = nn_ff[c];
         quo_in[0][c] = '0;
      end

      // one quotient bit per stage, msb first
      for (int s = 1; s <= NDIV; s++) begin
         k = NDIV - s;
         ds_in[s] = ds_ff[s-1];
         for (int c = 0; c < 3; c++) begin
            rem_in[s][c] = rem_ff[s-1][c];
            quo_in[s][c] = quo_ff[s-1][c];
            if ((rem_ff[s-1][c] >> k) >= den_ff[s-1]) begin
               rem_in[s][c] = rem_ff[s-1][c] - (den_ff[s-1] << k);
               quo_in[s][c] = quo_ff[s-1][c] | (QB'(1) << k);
            end
         end
      end

      // saturate and apply sign
      for (int c = 0; c < 3; c++) begin
         q  = quo_ff[NDIV][c];
         lim = ds_ff[NDIV].neg[c] ? LIM_NEG : LIM_POS;
         qs = (ds_ff[NDIV].ovf[c] || q > lim) ? lim : q;
         qn = ds_ff[NDIV].neg[c] ? ~qs + QB'(1) : qs;
         ctr_in[c] = ds_ff[NDIV].sing ? '0 : qn[CW-1:0];
      end

      // distance to first point
      for (int j = 0; j < 3; j++) begin
         dd_in[j]  = {ctr_ff[j][CW-1], ctr_ff[j]} - {bfa_ff[j][CW-1], bfa_ff[j]};
         sqd_in[j] = $signed(dd_ff[j]) * $signed(dd_ff[j]);
      end

      // root chain head
      srem_in[0] = RW'(sqd_ff[0]) + RW'(sqd_ff[1]) + RW'(sqd_ff[2]);
      root_in[0] = '0;

      // one root bit per stage; remainder stays sq - root^2
      for (int s = 1; s <= NSQ; s++) begin
         k = NSQ - s;
         t = (RW'(root_ff[s-1]) << (k + 1)) + (RW'(1) << (2 * k));
         srem_in[s] = srem_ff[s-1];
         root_in[s] = root_ff[s-1];
         if (srem_ff[s-1] >= t) begin
            srem_in[s] = srem_ff[s-1] - t;
            root_in[s] = root_ff[s-1] | (RB'(1) << k);
         end
      end

      // round the root, saturate
      r  = root_ff[NSQ];
      rr = {1'b0, r};
      if (srem_ff[NSQ] > RW'(r)) begin
         rr = rr + (RB + 1)'(1);
      end
      if (rs_ff[NSQ].sing) begin
         rad_in = '0;
      end else if (|rr[RB:RAD_W]) begin
         rad_in = '1;
      end else begin
         rad_in = rr[RAD_W-1:0];
      end
      cen_in = rs_ff[NSQ].ctr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an_ff  <= an_in;
         ad_ff  <= ad_in;
         s0_ff  <= s0_in;
         nn_ff  <= nn_in;
         dn1_ff <= dn1_in;
         s1_ff  <= s0_ff;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         ds_ff  <= ds_in;
         den_ff[0] <= dn1_ff;
         for (int s = 1; s <= NDIV; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         ctr_ff <= ctr_in;
         bfa_ff <= ds_ff[NDIV].a;
         bfs_ff <= ds_ff[NDIV].sing;
         dd_ff  <= dd_in;
         r1s_ff.sing <= bfs_ff;
         r1s_ff.ctr  <= ctr_ff;
         sqd_ff <= sqd_in;
         r2s_ff <= r1s_ff;
         srem_ff <= srem_in;
         root_ff <= root_in;
         rs_ff[0] <= r2s_ff;
         for (int s = 1; s <= NSQ; s++) begin
            rs_ff[s] <= rs_ff[s-1];
         end
         cen_ff <= cen_in;
         rad_ff <= rad_in;
         sng_ff <= rs_ff[NSQ].sing;
      end
   end

endmodule

### rtl/sphere_through_four_points.sv
// Sphere through four points. Each item carries four 3-D points in signed
// Q16.16 and returns the centre of the sphere through them and its radius
// (distance from the centre to the first point), both in the same format.
// The centre is the exact solution of the 3x3 system built from consecutive
// point pairs, rounded to nearest with ties away from zero and saturated;
// the radius is the rounded square root of the exact squared distance,
// saturated to 31 bits. Coplanar or repeated points give singular = 1 and
// all-zero fields. Throughput is one item per clock while rsp_ready is high.
// The front pipeline (differences, squares, cofactors, split 36x36
// products, sums, zero-determinant test) feeds the four-entry queue,
// which feeds the back pipeline, whose length is set mainly by the
// 33-stage restoring divider and the 36-stage square-root chain.
// Back-pressure on rsp stalls the back pipeline; the queue lets the front
// keep taking items until it fills.
`include "sphere_through_four_points_macros.svh"

module sphere_through_four_points import stp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_a_x,
   input  logic signed [31:0]  req_a_y,
   input  logic signed [31:0]  req_a_z,
   input  logic signed [31:0]  req_b_x,
   input  logic signed [31:0]  req_b_y,
   input  logic signed [31:0]  req_b_z,
   input  logic signed [31:0]  req_c_x,
   input  logic signed [31:0]  req_c_y,
   input  logic signed [31:0]  req_c_z,
   input  logic signed [31:0]  req_d_x,
   input  logic signed [31:0]  req_d_y,
   input  logic signed [31:0]  req_d_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_center_x,
   output logic signed [31:0]  rsp_center_y,
   output logic signed [31:0]  rsp_center_z,
   output logic [30:0]         rsp_radius,
   output logic                rsp_singular
);

   logic [3:0][2:0][CW-1:0]  pts;
   logic                     f_valid, f_ready;
   stp_job_type              f_job;
   logic                     b_valid, b_ready;
   stp_job_type              b_job;
   stp_qstat_type            qstat;
   logic [2:0][CW-1:0]       center;

   // points in item order: a, b, c, d
   assign pts[0] = {req_a_z, req_a_y, req_a_x};
   assign pts[1] = {req_b_z, req_b_y, req_b_x};
   assign pts[2] = {req_c_z, req_c_y, req_c_x};
   assign pts[3] = {req_d_z, req_d_y, req_d_x};

   // front: system set-up, determinant and numerators, singular test
   stp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pts    (pts),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_job   (f_job)
   );

   // decoupling queue
   stp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_job    (b_job),
      .stat       (qstat)
   );

   // back: divide, saturate, distance, square root
   stp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (b_valid),
      .in_ready     (b_ready),
      .in_job       (b_job),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_center   (center),
      .out_radius   (rsp_radius),
      .out_singular (rsp_singular)
   );

   assign rsp_center_x = center[0];
   assign rsp_center_y = center[1];
   assign rsp_center_z = center[2];

   // a singular item carries nothing but the flag
   `STP_ASSERT_IMP(a_sing_zero, rsp_valid && rsp_singular, rsp_center_x == 0 && rsp_center_y == 0 && rsp_center_z == 0 && rsp_radius == 0)
   // queue never written when full, never read when empty
   `STP_ASSERT_IMP(a_q_push, qstat.push, !qstat.full)
   `STP_ASSERT_IMP(a_q_pop, qstat.pop, !qstat.empty)
   // a full queue stays full until an item leaves
   `STP_ASSERT_NXT(a_q_hold, qstat.full && !qstat.pop, qstat.full)

endmodule
